/* rtl/core/relu_bound_relaxation_backsub_core_assert.svh */
// ----------------------------------------------------------------------------
// assertion macros for the relu bound relaxation core
// ----------------------------------------------------------------------------
`ifndef RELU_BOUND_RELAXATION_BACKSUB_CORE_ASSERT_SVH
`define RELU_BOUND_RELAXATION_BACKSUB_CORE_ASSERT_SVH

// clocked property, ignored while reset is high
`define RBR_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, also checked during reset
`define RBR_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/rbr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbr_pkg
// shared widths and constants of the relu bound relaxation core
// ----------------------------------------------------------------------------
package rbr_pkg;

  // fixed-point format default
  parameter int FRAC_BITS_DEF = 16;

  // field widths
  parameter int COEF_W = 32;
  parameter int ACC_W  = 48;
  parameter int IN_W   = 4 * COEF_W;
  parameter int OUT_W  = 2 * COEF_W + 2 * ACC_W;

  // saturation limits of the bias sums
  parameter logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  parameter logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

/* rtl/core/rbr_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbr_div
// radix-2 restoring divider for the upper slope, one quotient bit a cycle
// ----------------------------------------------------------------------------
module rbr_div #(
  parameter int FRAC_BITS = rbr_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [rbr_pkg::COEF_W-1:0]      num,
  input  logic [rbr_pkg::COEF_W-1:0]      den,
  output logic [FRAC_BITS:0]              quot,
  output logic                            done
);

  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam int W  = rbr_pkg::COEF_W;

  logic [W:0]    rem;
  logic [W-1:0]  dreg;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          take;

  // first step compares the numerator as is, later steps shift in a zero
  always_comb begin
    trial = (cnt == '0) ? rem : {rem[W-1:0], 1'b0};
    take  = trial >= {1'b0, dreg};
    diff  = trial - {1'b0, dreg};
  end

  // iteration control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= {1'b0, num};
        dreg <= den;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= take ? diff : trial;
        quot <= {quot[FRAC_BITS-1:0], take};
        if (cnt == CW'(FRAC_BITS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/relu_bound_relaxation_backsub_core.sv */
`timescale 1ns / 1ps
// one item at a time: the input is taken only while the sequencer is idle, so a new
// item waits until the last one's result sits in the output register
// the work of an item is the serial slope divider (FRAC_BITS + 1 steps) and
// five passes through the shared 32x32 multiplier; the output register frees the input
// reset: synchronous, clears the sequencer, the output valid and both bias sums
// ----------------------------------------------------------------------------
// relu_bound_relaxation_backsub_core
// back-substitutes lower and upper coefficients through one relu neuron per
// item and keeps saturating per-row bias sums
// ----------------------------------------------------------------------------
module relu_bound_relaxation_backsub_core #(
  parameter int FRAC_BITS = rbr_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // lower_bound, upper_bound, lower_coef, upper_coef
  input  logic [rbr_pkg::IN_W-1:0]   s_axis_tdata,
  input  logic                       s_axis_tlast,   // row_end
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // new_lower_coef, new_upper_coef, lower_bias_sum, upper_bias_sum
  output logic [rbr_pkg::OUT_W-1:0]  m_axis_tdata,
  output logic                       m_axis_tlast,   // sums_final
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready
);

  localparam int CW    = rbr_pkg::COEF_W;
  localparam int AW    = rbr_pkg::ACC_W;
  localparam int UPD_W = FRAC_BITS + 1;
  localparam int PW    = 2 * CW - FRAC_BITS;
  localparam int SW    = ((PW > AW) ? PW : AW) + 1;

  // multiply steps: first only issues, last only takes, the rest take and issue
  localparam logic [2:0] ISSUE_FIRST = 3'd0;
  localparam logic [2:0] TAKE_UPB    = 3'd1;
  localparam logic [2:0] TAKE_NL     = 3'd2;
  localparam logic [2:0] TAKE_LTERM  = 3'd3;
  localparam logic [2:0] TAKE_NU     = 3'd4;
  localparam logic [2:0] TAKE_UTERM  = 3'd5;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MUL, ST_ACC} state_t;

  state_t state;
  logic [2:0] step;

  // input decode
  logic signed [CW-1:0] in_lb, in_ub, in_lc, in_uc;
  logic [CW-1:0]        in_lbr_mag, in_ubr, in_den;
  logic                 in_lowd;
  logic                 accept;

  // item registers
  logic signed [CW-1:0] lc, uc;
  logic                 last;
  logic                 lowd;
  logic [CW-1:0]        lbr_mag;
  logic [UPD_W-1:0]     upd;
  logic [CW-1:0]        upb;
  logic signed [CW-1:0] nl, nu;
  logic signed [PW-1:0] lterm, uterm;

  // shared multiplier
  logic [CW-1:0]        mul_a, mul_b, lc_mag, uc_mag;
  logic [2*CW-1:0]      mul_p, prod;
  logic [PW-1:0]        prod_hi;

  // bias accumulation
  logic signed [AW-1:0] acc_l, acc_u, sat_l, sat_u;
  logic signed [SW-1:0] sum_l, sum_u;

  // output register
  logic signed [CW-1:0] o_nl, o_nu;
  logic signed [AW-1:0] o_lsum, o_usum;
  logic                 out_free;

  // divider
  logic [FRAC_BITS:0]   div_quot;
  logic                 div_done;

  assign in_lb = s_axis_tdata[CW-1:0];
  assign in_ub = s_axis_tdata[2*CW-1:CW];
  assign in_lc = s_axis_tdata[3*CW-1:2*CW];
  assign in_uc = s_axis_tdata[4*CW-1:3*CW];

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = {o_usum, o_lsum, o_nu, o_nl};

  // clamped bounds, slope denominator and lower slope choice
  always_comb begin
    in_lbr_mag = in_lb[CW-1] ? CW'(-in_lb) : '0;
    in_ubr     = (in_ub > 32'sd0) ? CW'(in_ub) : '0;
    if (in_lbr_mag == '0 && in_ubr == '0) begin
      in_ubr = CW'(1);
    end
    in_den = in_ubr + in_lbr_mag;
    if (!in_lb[CW-1]) begin
      in_lowd = 1'b1;
    end else begin
      in_lowd = (in_ub > 32'sd0) && (in_ubr > in_lbr_mag);
    end
  end

  rbr_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .num   (in_ubr),
    .den   (in_den),
    .quot  (div_quot),
    .done  (div_done)
  );

  // multiplier operand select
  always_comb begin
    lc_mag = lc[CW-1] ? CW'(-lc) : CW'(lc);
    uc_mag = uc[CW-1] ? CW'(-uc) : CW'(uc);
    unique case (step)
      ISSUE_FIRST: begin mul_a = lbr_mag; mul_b = CW'(upd); end
      TAKE_UPB:    begin mul_a = lc_mag;  mul_b = CW'(upd); end
      TAKE_NL:     begin mul_a = lc_mag;  mul_b = upb;      end
      TAKE_LTERM:  begin mul_a = uc_mag;  mul_b = CW'(upd); end
      TAKE_NU:     begin mul_a = uc_mag;  mul_b = upb;      end
      default:     begin mul_a = '0;      mul_b = '0;       end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign prod_hi = prod[2*CW-1:FRAC_BITS];

  // saturating bias sums
  always_comb begin
    sum_l = SW'(acc_l) + SW'(lterm);
    sum_u = SW'(acc_u) + SW'(uterm);
    if ((&sum_l[SW-1:AW-1]) || !(|sum_l[SW-1:AW-1])) begin
      sat_l = sum_l[AW-1:0];
    end else begin
      sat_l = sum_l[SW-1] ? rbr_pkg::ACC_MIN : rbr_pkg::ACC_MAX;
    end
    if ((&sum_u[SW-1:AW-1]) || !(|sum_u[SW-1:AW-1])) begin
      sat_u = sum_u[AW-1:0];
    end else begin
      sat_u = sum_u[SW-1] ? rbr_pkg::ACC_MIN : rbr_pkg::ACC_MAX;
    end
  end

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= ISSUE_FIRST;
      m_axis_tvalid <= 1'b0;
      acc_l         <= '0;
      acc_u         <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != ST_ACC) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            lc      <= in_lc;
            uc      <= in_uc;
            last    <= s_axis_tlast;
            lowd    <= in_lowd;
            lbr_mag <= in_lbr_mag;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            upd   <= div_quot;
            step  <= ISSUE_FIRST;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod <= mul_p;
          unique case (step)
            TAKE_UPB:   upb   <= prod_hi[CW-1:0];
            TAKE_NL:    nl    <= lc[CW-1] ? CW'(32'd0 - prod_hi[CW-1:0])
                                          : (lowd ? lc : '0);
            TAKE_LTERM: lterm <= lc[CW-1] ? ({PW{1'b0}} - prod_hi) : '0;
            TAKE_NU:    nu    <= uc[CW-1] ? (lowd ? uc : '0)
                                          : prod_hi[CW-1:0];
            TAKE_UTERM: uterm <= uc[CW-1] ? '0 : prod_hi;
            default: ;
          endcase
          if (step == TAKE_UTERM) begin
            state <= ST_ACC;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_ACC: begin
          if (out_free) begin
            o_nl          <= nl;
            o_nu          <= nu;
            o_lsum        <= sat_l;
            o_usum        <= sat_u;
            m_axis_tlast  <= last;
            m_axis_tvalid <= 1'b1;
            acc_l         <= last ? '0 : sat_l;
            acc_u         <= last ? '0 : sat_u;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/rbr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbr_checker
// port-level checks of the relu bound relaxation core
// ----------------------------------------------------------------------------
`include "relu_bound_relaxation_backsub_core_assert.svh"

module rbr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic [rbr_pkg::IN_W-1:0]   s_axis_tdata,
  input logic                       s_axis_tlast,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [rbr_pkg::OUT_W-1:0]  m_axis_tdata,
  input logic                       m_axis_tlast,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready
);

  logic s_acc;
  logic in_seen;

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign in_seen = s_acc && (s_axis_tlast || !s_axis_tlast) && (s_axis_tdata == s_axis_tdata);

  // reset empties the output register
  `RBR_ASSERT_ALWAYS(a_rst_out_empty, clk, rst |=> !m_axis_tvalid, "output valid after reset")

  // a taken item keeps the input closed for the start of the divider run
  `RBR_ASSERT(a_busy_after_item, clk, rst, in_seen |=> !s_axis_tready ##1 !s_axis_tready, "input reopened early")

  // a new result only appears at the end of an item's work
  `RBR_ASSERT(a_result_from_work, clk, rst, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result without work")

  // a stalled result item holds
  `RBR_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind relu_bound_relaxation_backsub_core rbr_checker u_rbr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
